// File: rtl/core/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg: shared types and constants for the drag rotation block
// Angle constants in Q30, the arctangent table and the rounding helper.
// ----------------------------------------------------------------------------
package drp_pkg;

    // Angle register width, wide enough for delta * step before reduction.
    localparam int ANGLE_W = 38;
    // CORDIC vector width, Q30 with headroom.
    localparam int VEC_W = 33;
    // Width of the sweep counters, holds any clamped grid size.
    localparam int CNT_W = 9;
    localparam int ATAN_COUNT = 24;

    localparam logic signed [ANGLE_W-1:0] ANGLE_STEP  = 38'sd7516193;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q30  = 38'sd6746518852;
    localparam logic signed [ANGLE_W-1:0] PI_Q30      = 38'sd3373259426;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 38'sd1686629713;
    localparam logic signed [VEC_W-1:0]   CORDIC_START = 33'sd652032874;

    // Action codes carried in the input tuser.
    localparam logic [2:0] ACT_PRESS   = 3'd0;
    localparam logic [2:0] ACT_MOVE    = 3'd1;
    localparam logic [2:0] ACT_RELEASE = 3'd2;
    localparam logic [2:0] ACT_WRITE   = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_BOX_W   = 2'd2;
    localparam logic [1:0] REG_BOX_H   = 2'd3;

    typedef logic signed [31:0] coord_t;

    // Arctangent of 2^-i in Q30.
    function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANGLE_W-1:0] v;
        case (i)
            5'd0:  v = 38'sd843314857;
            5'd1:  v = 38'sd497837829;
            5'd2:  v = 38'sd263043837;
            5'd3:  v = 38'sd133525159;
            5'd4:  v = 38'sd67021687;
            5'd5:  v = 38'sd33543516;
            5'd6:  v = 38'sd16775851;
            5'd7:  v = 38'sd8388437;
            5'd8:  v = 38'sd4194283;
            5'd9:  v = 38'sd2097149;
            5'd10: v = 38'sd1048576;
            5'd11: v = 38'sd524288;
            5'd12: v = 38'sd262144;
            5'd13: v = 38'sd131072;
            5'd14: v = 38'sd65536;
            5'd15: v = 38'sd32768;
            5'd16: v = 38'sd16384;
            5'd17: v = 38'sd8192;
            5'd18: v = 38'sd4096;
            5'd19: v = 38'sd2048;
            5'd20: v = 38'sd1024;
            5'd21: v = 38'sd512;
            5'd22: v = 38'sd256;
            5'd23: v = 38'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q46 sum to Q16 and saturate to 32 bits.
    function automatic coord_t round_sat(input logic signed [65:0] acc);
        logic signed [65:0] r;
        coord_t o;
        r = (acc + 66'sd536870912) >>> 30;
        if (r > 66'sd2147483647)
            o = 32'sh7FFFFFFF;
        else if (r < -66'sd2147483648)
            o = 32'sh80000000;
        else
            o = r[31:0];
        return o;
    endfunction

endpackage

// File: rtl/core/drp_ram.sv
// ----------------------------------------------------------------------------
// drp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/drp_cordic.sv
// ----------------------------------------------------------------------------
// drp_cordic: sine and cosine of delta * 0.007 rad
// Scales the delta, reduces modulo 2pi, folds into [-pi/2, pi/2] and runs
// rotation-mode CORDIC steps, one add/subtract step per cycle.
// ----------------------------------------------------------------------------
module drp_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [13:0]                delta,
    output logic                              done,
    output logic signed [drp_pkg::VEC_W-1:0]  cos_val,
    output logic signed [drp_pkg::VEC_W-1:0]  sin_val
);

    import drp_pkg::*;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_RED  = 3'd1;
    localparam logic [2:0] C_WRAP = 3'd2;
    localparam logic [2:0] C_FOLD = 3'd3;
    localparam logic [2:0] C_ITER = 3'd4;
    localparam logic [2:0] C_DONE = 3'd5;
    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

    logic [2:0] state_reg, state_next;
    logic signed [ANGLE_W-1:0] r_reg, r_next;
    logic signed [VEC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [4:0] step_reg, step_next;
    logic neg_reg, neg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
    end

    // Sequencer around one shared add/compare/shift step.
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        step_next  = step_reg;
        neg_next   = neg_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    r_next     = ANGLE_W'(delta) * ANGLE_STEP;
                    state_next = C_RED;
                end
            end
            C_RED:
            begin
                // Bring the angle into [0, 2pi) one period at a time.
                if (r_reg < 0)
                    r_next = r_reg + TWO_PI_Q30;
                else if (r_reg >= TWO_PI_Q30)
                    r_next = r_reg - TWO_PI_Q30;
                else
                    state_next = C_WRAP;
            end
            C_WRAP:
            begin
                if (r_reg >= PI_Q30)
                    r_next = r_reg - TWO_PI_Q30;
                state_next = C_FOLD;
            end
            C_FOLD:
            begin
                // Fold into the CORDIC range; a fold negates both results.
                neg_next = 1'b0;
                if (r_reg > HALF_PI_Q30)
                begin
                    r_next   = r_reg - PI_Q30;
                    neg_next = 1'b1;
                end
                else if (r_reg < -HALF_PI_Q30)
                begin
                    r_next   = r_reg + PI_Q30;
                    neg_next = 1'b1;
                end
                x_next     = CORDIC_START;
                y_next     = '0;
                step_next  = '0;
                state_next = C_ITER;
            end
            C_ITER:
            begin
                if (r_reg >= 0)
                begin
                    x_next = x_reg - (y_reg >>> step_reg);
                    y_next = y_reg + (x_reg >>> step_reg);
                    r_next = r_reg - atan_q30(step_reg);
                end
                else
                begin
                    x_next = x_reg + (y_reg >>> step_reg);
                    y_next = y_reg - (x_reg >>> step_reg);
                    r_next = r_reg + atan_q30(step_reg);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_STEP)
                    state_next = C_DONE;
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Results hold from the done cycle on.
    assign done    = (state_reg == C_DONE);
    assign cos_val = neg_reg ? -x_reg : x_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;

endmodule

// File: rtl/core/drag_rotate_point_grid.sv
// ----------------------------------------------------------------------------
// drag_rotate_point_grid: mouse-drag rotation of a grid of 3D points
// Keeps the point grid and the drag state and rotates the grid on moves.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive on the s_axis channel, the kind of event in tuser. Every
// accepted beat yields exactly one m_axis beat. The user writes registers
// on the cfg channel only while the block is idle; the block does not
// enforce this, and cfg_ready is always high. A press, release or write
// result passes the EXEC and DONE states before it enters the output
// register, a read inside the grid also the READ state, and the input is
// ready again once the result is in that register. A rotating move waits,
// per rotated plane, on the CORDIC unit, whose run the modulo reduction
// steps and CORDIC_STEPS set, then sweeps the cols*rows memory points, one
// point per cycle through the rotation pipeline; the memory port sets that.
// s_axis_tready is low while an event is processed, one event at a time.
// The next event is taken while a result waits on m_axis; a finished
// result waits in the block while the receiver stalls.
// Reset clears the drag state and the registers to 0, 0, 100 and 30. The
// point memory is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module drag_rotate_point_grid #(
    parameter int MAX_COLUMNS  = 64,
    parameter int MAX_ROWS     = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // button[2:0], cursor_x[15:3], cursor_y[28:16], point_column[34:29],
    // point_row[40:35], coord_x[72:41], coord_y[104:73], coord_z[136:105]
    input  logic [143:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quit_request[0], rotations_done[2:1], read_x[34:3], read_y[66:35],
    // read_z[98:67]
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data
);

    import drp_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_SC   = 3'd3;
    localparam logic [2:0] ST_ROT  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    // Configuration registers.
    logic [6:0]  columns_reg, rows_reg;
    logic [11:0] box_w_reg, box_h_reg;

    // Drag state.
    logic drag_reg, drag_next;
    logic signed [12:0] last_x_reg, last_x_next, last_y_reg, last_y_next;

    // Latched command.
    logic [2:0]  act_reg;
    logic [2:0]  btn_reg;
    logic signed [12:0] cx_reg, cy_reg;
    logic [5:0]  col_reg, row_reg;
    logic [95:0] pt_reg;

    // Move bookkeeping.
    logic en_y_reg, en_y_next;
    logic signed [13:0] dy_reg, dy_next;
    logic plane_reg, plane_next;

    // Result registers.
    logic res_quit_reg, res_quit_next;
    logic [1:0] res_rot_reg, res_rot_next;
    coord_t res_x_reg, res_x_next, res_y_reg, res_y_next, res_z_reg, res_z_next;

    // Output register.
    logic m_valid_reg;
    logic [103:0] m_data_reg;

    // CORDIC link.
    logic cs_start;
    logic signed [13:0] cs_delta;
    logic cs_done;
    logic signed [VEC_W-1:0] cs_cos, cs_sin;
    logic signed [VEC_W-1:0] c_reg, c_next, s_reg, s_next;

    // Sweep and rotation pipeline.
    logic [CNT_W-1:0] sc_col_reg, sc_col_next, sc_row_reg, sc_row_next;
    logic issue_reg, issue_next;
    logic v1_reg, v2_reg;
    logic [AW-1:0] a1_reg, a2_reg;
    logic [CNT_W-1:0] cols_use, rows_use;
    logic signed [64:0] p_ac_reg, p_zs_reg, p_zc_reg, p_as_reg;
    coord_t keep_reg;
    coord_t new_a, new_z;

    // Memory ports.
    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [95:0] wr_data, rd_data;
    coord_t rd_x, rd_y, rd_z, op_a;

    logic in_grid, quit_hit;
    logic [AW-1:0] cmd_addr, sweep_addr;

    drp_ram #(
        .WIDTH(96),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    drp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cs_start),
        .delta  (cs_delta),
        .done   (cs_done),
        .cos_val(cs_cos),
        .sin_val(cs_sin)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Grid size clamped to the memory's shape.
    assign cols_use = (CNT_W'(columns_reg) > CNT_W'(MAX_COLUMNS)) ?
                      CNT_W'(MAX_COLUMNS) : CNT_W'(columns_reg);
    assign rows_use = (CNT_W'(rows_reg) > CNT_W'(MAX_ROWS)) ?
                      CNT_W'(MAX_ROWS) : CNT_W'(rows_reg);

    assign in_grid  = (CNT_W'(col_reg) < CNT_W'(MAX_COLUMNS)) &&
                      (CNT_W'(row_reg) < CNT_W'(MAX_ROWS));
    assign cmd_addr   = AW'(32'(col_reg) * MAX_ROWS + 32'(row_reg));
    assign sweep_addr = AW'(32'(sc_col_reg) * MAX_ROWS + 32'(sc_row_reg));
    assign quit_hit = (btn_reg == 3'd1) &&
                      (14'(cx_reg) < $signed({2'b00, box_w_reg})) &&
                      (14'(cy_reg) < $signed({2'b00, box_h_reg}));

    assign rd_x = rd_data[31:0];
    assign rd_y = rd_data[63:32];
    assign rd_z = rd_data[95:64];
    assign op_a = plane_reg ? rd_y : rd_x;

    // Rounded rotation results of the point in the product stage.
    assign new_a = round_sat(66'(p_ac_reg) + 66'(p_zs_reg));
    assign new_z = round_sat(66'(p_zc_reg) - 66'(p_as_reg));

    // Memory write: a point write command or a rotated point.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd_addr;
        wr_data = pt_reg;
        if (v2_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = a2_reg;
            wr_data = plane_reg ? {new_z, new_a, keep_reg} : {new_z, keep_reg, new_a};
        end
        else if (state_reg == ST_EXEC && act_reg == ACT_WRITE && in_grid)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr = (state_reg == ST_ROT) ? sweep_addr : cmd_addr;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= '0;
            rows_reg    <= '0;
            box_w_reg   <= 12'd100;
            box_h_reg   <= 12'd30;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COLUMNS: columns_reg <= cfg_data[6:0];
                REG_ROWS:    rows_reg    <= cfg_data[6:0];
                REG_BOX_W:   box_w_reg   <= cfg_data;
                REG_BOX_H:   box_h_reg   <= cfg_data;
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            drag_reg    <= 1'b0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            issue_reg   <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            drag_reg   <= drag_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            issue_reg  <= issue_next;
            v1_reg     <= issue_reg;
            v2_reg     <= v1_reg;
            if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready))
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            act_reg <= s_axis_tuser;
            btn_reg <= s_axis_tdata[2:0];
            cx_reg  <= s_axis_tdata[15:3];
            cy_reg  <= s_axis_tdata[28:16];
            col_reg <= s_axis_tdata[34:29];
            row_reg <= s_axis_tdata[40:35];
            pt_reg  <= {s_axis_tdata[136:105], s_axis_tdata[104:73], s_axis_tdata[72:41]};
        end
        en_y_reg     <= en_y_next;
        dy_reg       <= dy_next;
        plane_reg    <= plane_next;
        c_reg        <= c_next;
        s_reg        <= s_next;
        sc_col_reg   <= sc_col_next;
        sc_row_reg   <= sc_row_next;
        res_quit_reg <= res_quit_next;
        res_rot_reg  <= res_rot_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        // Rotation pipeline: address, memory data, products, write back.
        a1_reg   <= sweep_addr;
        a2_reg   <= a1_reg;
        p_ac_reg <= op_a * c_reg;
        p_zs_reg <= rd_z * s_reg;
        p_zc_reg <= rd_z * c_reg;
        p_as_reg <= op_a * s_reg;
        keep_reg <= plane_reg ? rd_x : rd_y;
        if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready))
            m_data_reg <= {5'd0, res_z_reg, res_y_reg, res_x_reg, res_rot_reg, res_quit_reg};
    end

    // Event sequencer.
    always_comb
    begin
        state_next    = state_reg;
        drag_next     = drag_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        en_y_next     = en_y_reg;
        dy_next       = dy_reg;
        plane_next    = plane_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        sc_col_next   = sc_col_reg;
        sc_row_next   = sc_row_reg;
        issue_next    = issue_reg;
        res_quit_next = res_quit_reg;
        res_rot_next  = res_rot_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_z_next    = res_z_reg;
        cs_start      = 1'b0;
        cs_delta      = 14'(cx_reg) - 14'(last_x_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_quit_next = 1'b0;
                    res_rot_next  = '0;
                    res_x_next    = '0;
                    res_y_next    = '0;
                    res_z_next    = '0;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (act_reg)
                    ACT_PRESS:
                    begin
                        if (quit_hit)
                            res_quit_next = 1'b1;
                        else
                            drag_next = 1'b1;
                    end
                    ACT_MOVE:
                    begin
                        last_x_next = cx_reg;
                        last_y_next = cy_reg;
                        dy_next     = 14'(cy_reg) - 14'(last_y_reg);
                        en_y_next   = drag_reg && (last_y_reg != 0) && (cy_reg != last_y_reg);
                        if (drag_reg && (last_y_reg != 0) && (cx_reg != last_x_reg))
                        begin
                            cs_start     = 1'b1;
                            plane_next   = 1'b0;
                            res_rot_next = 2'b01;
                            state_next   = ST_SC;
                        end
                        else if (drag_reg && (last_y_reg != 0) && (cy_reg != last_y_reg))
                        begin
                            cs_start     = 1'b1;
                            cs_delta     = 14'(cy_reg) - 14'(last_y_reg);
                            plane_next   = 1'b1;
                            res_rot_next = 2'b10;
                            state_next   = ST_SC;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        drag_next   = 1'b0;
                        last_x_next = '0;
                        last_y_next = '0;
                    end
                    ACT_READ:
                    begin
                        if (in_grid)
                            state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ:
            begin
                res_x_next = rd_x;
                res_y_next = rd_y;
                res_z_next = rd_z;
                state_next = ST_DONE;
            end
            ST_SC:
            begin
                // Wait for sine and cosine, then start the sweep.
                if (cs_done)
                begin
                    c_next      = cs_cos;
                    s_next      = cs_sin;
                    sc_col_next = '0;
                    sc_row_next = '0;
                    issue_next  = (cols_use != 0) && (rows_use != 0);
                    state_next  = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (issue_reg)
                begin
                    if (sc_row_reg == rows_use - 1'b1)
                    begin
                        sc_row_next = '0;
                        sc_col_next = sc_col_reg + 1'b1;
                        if (sc_col_reg == cols_use - 1'b1)
                            issue_next = 1'b0;
                    end
                    else
                    begin
                        sc_row_next = sc_row_reg + 1'b1;
                    end
                end
                else if (!v1_reg && !v2_reg)
                begin
                    if (!plane_reg && en_y_reg)
                    begin
                        cs_start     = 1'b1;
                        cs_delta     = dy_reg;
                        plane_next   = 1'b1;
                        res_rot_next = res_rot_reg | 2'b10;
                        state_next   = ST_SC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Rotated points are written back only during a sweep.
    a_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (state_reg == ST_ROT))
        else $error("rotation write-back outside a sweep");

    // The CORDIC unit finishes only while the sequencer waits for it.
    a_cs_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cs_done |-> (state_reg == ST_SC))
        else $error("CORDIC result arrived while not waiting");

    // A sweep never starts without a rotation flagged in the result.
    a_rot_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT) |-> (res_rot_reg != 2'b00))
        else $error("sweep without rotation flag");

endmodule
